// File: hw/rtl/imrr_pkg.sv
`default_nettype none

package imrr_pkg;

  localparam int ARRAY_DIM    = 16;
  localparam int GROUP_COUNT  = 1;
  localparam int SLAB         = ((ARRAY_DIM / GROUP_COUNT) > 0) ? (ARRAY_DIM / GROUP_COUNT) : 1;
  localparam int ROW_LEN      = GROUP_COUNT * ARRAY_DIM;
  localparam int STORE_DEPTH  = ROW_LEN * SLAB;
  localparam int SHIFT_AMOUNT = 2;

  localparam int ACC_W  = 32;
  localparam int DATA_W = 8;
  localparam int ADDR_W = 8;
  localparam int COL_W  = 4;
  localparam int POS_W  = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
  localparam int IDX_W  = (SLAB > 1) ? $clog2(SLAB) : 1;
  localparam int CNT_W  = $clog2(SLAB + 1);

  typedef struct packed {
    logic                     wr_en;
    logic                     mac_en;
    logic                     last;
    logic                     shift;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] wval;
    logic signed [DATA_W-1:0] act;
    logic [POS_W-1:0]         pos;
  } imrr_req_t;

  function automatic logic signed [DATA_W-1:0] requant(input logic [ACC_W-1:0] acc);
    logic signed [DATA_W-1:0] res;
    if (acc[ACC_W-1]) begin
      res = '0;
    end else begin
      res = DATA_W'(acc >> SHIFT_AMOUNT);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/imrr_cell.sv
`default_nettype none

module imrr_cell
  import imrr_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  imrr_req_t                req_i,
  input  wire [IDX_W-1:0]          col_i,
  input  wire signed [DATA_W-1:0]  res_next_i,
  output logic signed [DATA_W-1:0] res_o
);

  logic signed [DATA_W-1:0]   w_q [ROW_LEN];
  logic [ACC_W-1:0]           acc_q;
  logic signed [DATA_W-1:0]   res_q;
  logic signed [DATA_W-1:0]   w_rd;
  logic signed [2*DATA_W-1:0] prod;
  logic [ACC_W-1:0]           acc_sum;

  assign w_rd    = w_q[req_i.pos];
  assign prod    = req_i.act * w_rd;
  assign acc_sum = acc_q + ACC_W'(prod);
  assign res_o   = res_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ROW_LEN; k++) begin
      if (req_i.wr_en && (int'(req_i.addr) == k * SLAB + int'(col_i))) begin
        w_q[k] <= req_i.wval;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (req_i.mac_en) begin
      acc_q <= req_i.last ? '0 : acc_sum;
    end
  end

  // load on row end, else advance from neighbor
  always_ff @(posedge clk_i) begin
    if (req_i.mac_en && req_i.last) begin
      res_q <= requant(acc_sum);
    end else if (req_i.shift) begin
      res_q <= res_next_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/int8_matvec_relu_requant.sv
// int8 matrix-vector unit, weight stationary: a row of cells, one per output column, each
// holding that column's int8 weights and a 32-bit wrapping accumulator. Mode 0 requests write
// one weight at flat address k*16+c; mode 1 requests carry one activation, which every cell
// multiplies by its weight of the current row position in the cycle it is accepted. The
// 16th activation of a row loads relu(acc)>>2 (low 8 bits) of every column into a result chain
// shifting out toward column 0, one result per unstalled cycle, and clears the accumulators.
// One request is accepted per cycle. Only a request at the row's last position can wait (the
// row-ending activation, or a weight write then): it is stalled until the previous row's
// results have left the chain, so with an unstalled output, full rows run back to back.
`default_nettype none

module int8_matvec_relu_requant
  import imrr_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire                      mode_i,
  input  wire [ADDR_W-1:0]         weight_address_i,
  input  wire signed [DATA_W-1:0]  weight_value_i,
  input  wire signed [DATA_W-1:0]  activation_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output logic [COL_W-1:0]         column_o,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic                     last_of_row_o
);

  localparam logic [POS_W-1:0] LastPos = POS_W'(ROW_LEN - 1);

  logic [POS_W-1:0]         pos_q, pos_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     in_fire, out_fire, chain_free, mac, row_end;
  imrr_req_t                req;
  logic signed [DATA_W-1:0] res [SLAB];

  assign out_valid_o    = (cnt_q != '0);
  assign out_fire       = out_valid_o && !out_stall_i;
  assign chain_free     = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_fire);
  assign row_end        = (pos_q == LastPos);
  assign in_stall_o     = row_end && !chain_free;
  assign in_fire        = in_valid_i && !in_stall_o;
  assign mac            = in_fire && mode_i;

  assign column_o       = COL_W'(CNT_W'(SLAB) - cnt_q);
  assign last_of_row_o  = (cnt_q == CNT_W'(1));
  assign result_value_o = res[0];

  always_comb begin
    req.wr_en  = in_fire && !mode_i;
    req.mac_en = mac;
    req.last   = row_end;
    req.shift  = out_fire;
    req.addr   = weight_address_i;
    req.wval   = weight_value_i;
    req.act    = activation_i;
    req.pos    = pos_q;
  end

  always_comb begin
    pos_d = pos_q;
    if (mac) begin
      pos_d = row_end ? '0 : pos_q + POS_W'(1);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (mac && row_end) begin
      cnt_d = CNT_W'(SLAB);
    end else if (out_fire) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
    end else begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end

  for (genvar i = 0; i < SLAB; i++) begin : g_cell
    logic signed [DATA_W-1:0] nxt;
    if (i == SLAB - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_link
      assign nxt = res[i+1];
    end
    imrr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .req_i      (req),
      .col_i      (IDX_W'(i)),
      .res_next_i (nxt),
      .res_o      (res[i])
    );
  end

endmodule

`default_nettype wire

// File: hw/rtl/imrr_checker.sv
`default_nettype none

module imrr_checker
  import imrr_pkg::*;
(
  input wire                     clk_i,
  input wire                     rst_ni,
  input wire                     out_valid_o,
  input wire                     out_stall_i,
  input wire [COL_W-1:0]         column_o,
  input wire signed [DATA_W-1:0] result_value_o,
  input wire                     last_of_row_o
);

  localparam logic [COL_W-1:0] LastCol = COL_W'(SLAB - 1);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(column_o)
      && $stable(result_value_o) && $stable(last_of_row_o))
    else $error("stalled result changed");

  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_row_o |-> column_o == LastCol)
    else $error("row end on wrong column");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_row_o |=>
      out_valid_o && column_o == $past(column_o) + COL_W'(1))
    else $error("column order broken");

  a_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_of_row_o |=> !out_valid_o || column_o == '0)
    else $error("row does not start at column zero");

endmodule

bind int8_matvec_relu_requant imrr_checker u_imrr_checker (.*);

`default_nettype wire
